@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared sizes, status codes, request and response types and the command and
// status structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Number of slots in the queue.
  localparam int DEPTH = 16;
  // Width of the entry counter, wide enough to hold DEPTH itself.
  localparam int CNT_W = $clog2(DEPTH + 1);
  // Width of the reported fill level.
  localparam int FILL_W = 5;

  // Operation kinds.
  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // One request as presented on the input side.
  typedef struct packed {
    logic               kind;
    logic [31:0]        entry_id;
    logic signed [31:0] priority_key;
    logic [31:0]        payload;
  } req_t;

  // One result as presented on the output side.
  typedef struct packed {
    logic [1:0]        status;
    logic [31:0]       out_id;
    logic [31:0]       out_payload;
    logic [FILL_W-1:0] fill_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } spq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
  } spq_stat_t;

endpackage

@@ rtl/spq_datapath.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// Request register, a row of slot cells with compare-and-shift logic, the
// entry counter and the response register.
// ----------------------------------------------------------------------------
module spq_datapath (
  input  logic              clk,
  input  logic              rst,
  input  spq_pkg::spq_cmd_t cmd,
  input  spq_pkg::req_t     req,
  output spq_pkg::spq_stat_t stat,
  output spq_pkg::rsp_t     rsp
);

  spq_pkg::req_t             req_q;
  logic [spq_pkg::CNT_W-1:0] count;
  logic [spq_pkg::CNT_W-1:0] count_next;

  logic [31:0]        slot_id      [spq_pkg::DEPTH];
  logic [31:0]        slot_payload [spq_pkg::DEPTH];
  logic signed [31:0] slot_prio    [spq_pkg::DEPTH];

  logic [31:0]        slot_id_next      [spq_pkg::DEPTH];
  logic [31:0]        slot_payload_next [spq_pkg::DEPTH];
  logic signed [31:0] slot_prio_next    [spq_pkg::DEPTH];

  // Per-slot flag: slot holds an entry that must leave after the new one.
  logic [spq_pkg::DEPTH-1:0] after_new;

  logic full;
  logic empty;
  spq_pkg::rsp_t rsp_next;

  assign full  = (count == spq_pkg::CNT_W'(spq_pkg::DEPTH));
  assign empty = (count == '0);
  assign stat  = '{full: full, empty: empty};

  // Capture the request when the controller accepts it.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
  end

  // Compare every stored priority against the new key in parallel.
  always_comb begin
    for (int i = 0; i < spq_pkg::DEPTH; i++) begin
      after_new[i] = (spq_pkg::CNT_W'(i) < count) && (slot_prio[i] > req_q.priority_key);
    end
  end

  // Next contents of each cell: shift towards the tail on insert, towards the
  // head on extract, and load the new entry at the first later slot, else at slot count.
  always_comb begin
    for (int i = 0; i < spq_pkg::DEPTH; i++) begin
      slot_id_next[i]      = slot_id[i];
      slot_payload_next[i] = slot_payload[i];
      slot_prio_next[i]    = slot_prio[i];
      if (req_q.kind == spq_pkg::KIND_EXTRACT) begin
        if (i < spq_pkg::DEPTH - 1) begin
          slot_id_next[i]      = slot_id[i + 1];
          slot_payload_next[i] = slot_payload[i + 1];
          slot_prio_next[i]    = slot_prio[i + 1];
        end
      end else if ((i > 0) && after_new[(i > 0) ? i - 1 : 0]) begin
        slot_id_next[i]      = slot_id[(i > 0) ? i - 1 : 0];
        slot_payload_next[i] = slot_payload[(i > 0) ? i - 1 : 0];
        slot_prio_next[i]    = slot_prio[(i > 0) ? i - 1 : 0];
      end else if (after_new[i] || (spq_pkg::CNT_W'(i) == count)) begin
        slot_id_next[i]      = req_q.entry_id;
        slot_payload_next[i] = req_q.payload;
        slot_prio_next[i]    = req_q.priority_key;
      end
    end
  end

  // Result and new fill level for the request in hand.
  always_comb begin
    count_next = count;
    rsp_next   = '{status: spq_pkg::ST_OK, out_id: '0, out_payload: '0, fill_count: '0};
    if (req_q.kind == spq_pkg::KIND_EXTRACT) begin
      if (empty) begin
        rsp_next.status = spq_pkg::ST_EMPTY;
      end else begin
        rsp_next.out_id      = slot_id[0];
        rsp_next.out_payload = slot_payload[0];
        count_next           = count - spq_pkg::CNT_W'(1);
      end
    end else begin
      if (full) begin
        rsp_next.status = spq_pkg::ST_FULL;
      end else begin
        count_next = count + spq_pkg::CNT_W'(1);
      end
    end
    rsp_next.fill_count = spq_pkg::FILL_W'(count_next);
  end

  // Slot storage is only written when the operation succeeds.
  always_ff @(posedge clk) begin
    if (cmd.exec && (count_next != count)) begin
      for (int i = 0; i < spq_pkg::DEPTH; i++) begin
        slot_id[i]      <= slot_id_next[i];
        slot_payload[i] <= slot_payload_next[i];
        slot_prio[i]    <= slot_prio_next[i];
      end
    end
  end

  // Entry counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  // Response register, shown on the strobe cycle that follows execution.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp <= rsp_next;
    end
  end

  // The counter never passes the number of slots.
  assert property (@(posedge clk) disable iff (rst)
    count <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
    else $error("entry count above depth");

  // A successful insert raises the count by one.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && (req_q.kind == spq_pkg::KIND_INSERT) && !full)
      |=> (count == $past(count) + spq_pkg::CNT_W'(1)))
    else $error("insert did not raise the count");

  // An extract on an empty queue reports empty with zero data.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && (req_q.kind == spq_pkg::KIND_EXTRACT) && empty)
      |=> ((rsp.status == spq_pkg::ST_EMPTY) && (rsp.out_id == '0) && (count == '0)))
    else $error("empty extract misreported");

endmodule

@@ rtl/spq_controller.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Accepts a request, runs the execute state in the datapath and raises the
// result strobe in the cycle after it.
// ----------------------------------------------------------------------------
module spq_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  spq_pkg::spq_stat_t  stat,
  output logic                busy,
  output logic                done,
  output spq_pkg::spq_cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result strobe registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EXEC);
    end
  end

  // Commands to the datapath.
  assign busy     = (state == S_EXEC);
  assign cmd.load = start && (state == S_IDLE);
  assign cmd.exec = (state == S_EXEC);

  // An accepted request is executed in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> cmd.exec)
    else $error("accepted request not executed");

  // Every execute cycle is followed by exactly one strobe.
  assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> (done && !cmd.exec))
    else $error("execute not followed by a single strobe");

  // A queue of at least one slot is never full and empty at once.
  assert property (@(posedge clk) disable iff (rst)
    !(stat.full && stat.empty))
    else $error("datapath reports full and empty together");

endmodule

@@ rtl/sorted_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Holds up to DEPTH entries sorted by ascending signed Q16.16 priority and
// serves insert and extract requests, one at a time.
// ----------------------------------------------------------------------------
// Each request passes through the cycle in which start is taken and the
// execute state, in which all slots compare against the new key and shift in
// parallel. The result appears on rsp with done high for exactly one cycle,
// the cycle after execution, and busy is low again in that same cycle, so a
// new request can be taken then. The receiver cannot stall: it must take the
// result in the cycle that done marks. Equal priorities leave in arrival
// order; an insert into a full queue reports a full status and an extract
// from an empty queue reports an empty status with zero data.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  spq_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output spq_pkg::rsp_t rsp
);

  spq_pkg::spq_cmd_t  cmd;
  spq_pkg::spq_stat_t stat;

  // Sequencing of each request.
  spq_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Slot storage and compare-and-shift logic.
  spq_datapath u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .req  (req),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule
